@@ rtl/bdc_pkg.sv @@
// shared types, codes and helper functions for the braille dot canvas
// no dependencies; the dot sequencer, cell store and top file refer to it by scoped names
`timescale 1ns / 1ps

package bdc_pkg;

  localparam int COORD_W  = 11;  // dot coordinate with one guard bit
  localparam int CFG_IDX_W = 2;

  // command codes on the op field
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LINE  = 2'd1;
  localparam logic [1:0] OP_MARK  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_COLS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_ROWS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ASCII_GLYPHS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_COLOR = 2'd3;

  localparam logic [13:0] BRAILLE_BASE = 14'h2800;

  localparam logic [13:0] GLYPH_SPACE = 14'h0020;
  localparam logic [13:0] GLYPH_BAR   = 14'h007C;
  localparam logic [13:0] GLYPH_COLON = 14'h003A;
  localparam logic [13:0] GLYPH_APOS  = 14'h0027;
  localparam logic [13:0] GLYPH_DASH  = 14'h002D;
  localparam logic [13:0] GLYPH_DOT   = 14'h002E;
  localparam logic [13:0] GLYPH_UNDER = 14'h005F;

  // one dot handed from the sequencer to the cell store
  typedef struct packed {
    logic                       valid;
    logic                       last;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
  } dot_t;

  // braille bit of a dot inside its 2x4 cell
  function automatic logic [7:0] dot_bit(input logic xo, input logic [1:0] yo);
    logic [7:0] b;
    case ({xo, yo})
      3'b000:  b = 8'h01;
      3'b001:  b = 8'h02;
      3'b010:  b = 8'h04;
      3'b011:  b = 8'h40;
      3'b100:  b = 8'h08;
      3'b101:  b = 8'h10;
      3'b110:  b = 8'h20;
      3'b111:  b = 8'h80;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // ascii stand-in picked from the span of occupied dot rows
  function automatic logic [13:0] ascii_glyph(input logic [7:0] m);
    logic [3:0]  occ;
    logic [1:0]  top;
    logic [1:0]  bot;
    logic [13:0] g;
    occ = {m[7] | m[6], m[5] | m[2], m[4] | m[1], m[3] | m[0]};
    top = 2'd0;
    bot = 2'd0;
    for (int r = 3; r >= 0; r--) begin
      if (occ[r]) top = 2'(r);
    end
    for (int r = 0; r < 4; r++) begin
      if (occ[r]) bot = 2'(r);
    end
    if (occ == 4'b0000) begin
      g = GLYPH_SPACE;
    end else if (bot - top >= 2'd2) begin
      g = GLYPH_BAR;
    end else if (bot - top == 2'd1) begin
      g = GLYPH_COLON;
    end else begin
      case (top)
        2'd0:    g = GLYPH_APOS;
        2'd1:    g = GLYPH_DASH;
        2'd2:    g = GLYPH_DOT;
        2'd3:    g = GLYPH_UNDER;
        default: g = GLYPH_SPACE;
      endcase
    end
    return g;
  endfunction

endpackage

@@ rtl/bdc_in_if.sv @@
// command channel: valid/ready handshake and the command word
// uses no package
`timescale 1ns / 1ps

interface bdc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [9:0]  x_start;
  logic signed [9:0]  y_start;
  logic signed [9:0]  x_end;
  logic signed [9:0]  y_end;
  logic [7:0]         color;
  logic [11:0]        cell_index;

  modport source (output valid, op, x_start, y_start, x_end, y_end, color, cell_index,
                  input ready);
  modport sink   (input valid, op, x_start, y_start, x_end, y_end, color, cell_index,
                  output ready);
endinterface

@@ rtl/bdc_out_if.sv @@
// result channel: valid/ready handshake and the result word
// uses no package
`timescale 1ns / 1ps

interface bdc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cell_mask;
  logic [7:0]  cell_color;
  logic [13:0] glyph;
  logic        read_valid;

  modport source (output valid, cell_mask, cell_color, glyph, read_valid, input ready);
  modport sink   (input valid, cell_mask, cell_color, glyph, read_valid, output ready);
endinterface

@@ rtl/bdc_dot_gen.sv @@
// dot sequencer: bresenham stepper for lines, five-step walk for markers
// depends on bdc_pkg (dot_t, COORD_W)
`timescale 1ns / 1ps

module bdc_dot_gen (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              mode_line,
  input  logic signed [9:0] x0,
  input  logic signed [9:0] y0,
  input  logic signed [9:0] x1,
  input  logic signed [9:0] y1,
  output bdc_pkg::dot_t     dot
);

  localparam logic [2:0] MARK_LAST = 3'd4;

  logic                              busy_r, busy_nxt;
  logic                              line_r, line_nxt;
  logic signed [bdc_pkg::COORD_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [bdc_pkg::COORD_W-1:0] xe_r, xe_nxt, ye_r, ye_nxt;
  logic [9:0]                        adx_r, adx_nxt, ady_r, ady_nxt;
  logic                              sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [12:0]                err_r, err_nxt;
  logic [2:0]                        cnt_r, cnt_nxt;

  logic signed [10:0] dfx, dfy;
  logic [9:0]         adx, ady;
  logic signed [13:0] e2, lo_lim, hi_lim;
  logic               step_x, step_y, at_end;
  logic signed [bdc_pkg::COORD_W-1:0] ox, oy, xs, ys;

  always_comb begin
    dfx = {x1[9], x1} - {x0[9], x0};
    dfy = {y1[9], y1} - {y0[9], y0};
    adx = dfx[10] ? 10'(-dfx) : dfx[9:0];
    ady = dfy[10] ? 10'(-dfy) : dfy[9:0];

    // shared step unit: error term test and update
    e2     = {err_r, 1'b0};
    lo_lim = -$signed({4'b0000, ady_r});
    hi_lim = $signed({4'b0000, adx_r});
    step_x = e2 >= lo_lim;
    step_y = e2 <= hi_lim;
    at_end = (x_r == xe_r) && (y_r == ye_r);
    xs     = sx_r ? 11'sd1 : -11'sd1;
    ys     = sy_r ? 11'sd1 : -11'sd1;

    // cross: centre, left, right, up, down
    case (cnt_r)
      3'd1:    begin ox = -11'sd1; oy = 11'sd0;  end
      3'd2:    begin ox = 11'sd1;  oy = 11'sd0;  end
      3'd3:    begin ox = 11'sd0;  oy = -11'sd1; end
      3'd4:    begin ox = 11'sd0;  oy = 11'sd1;  end
      default: begin ox = 11'sd0;  oy = 11'sd0;  end
    endcase

    dot.valid = busy_r;
    dot.last  = line_r ? at_end : (cnt_r == MARK_LAST);
    dot.x     = line_r ? x_r : x_r + ox;
    dot.y     = line_r ? y_r : y_r + oy;

    busy_nxt = busy_r;
    line_nxt = line_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    xe_nxt   = xe_r;
    ye_nxt   = ye_r;
    adx_nxt  = adx_r;
    ady_nxt  = ady_r;
    sx_nxt   = sx_r;
    sy_nxt   = sy_r;
    err_nxt  = err_r;
    cnt_nxt  = cnt_r;

    if (start) begin
      busy_nxt = 1'b1;
      line_nxt = mode_line;
      x_nxt    = {x0[9], x0};
      y_nxt    = {y0[9], y0};
      xe_nxt   = {x1[9], x1};
      ye_nxt   = {y1[9], y1};
      adx_nxt  = adx;
      ady_nxt  = ady;
      sx_nxt   = x0 < x1;
      sy_nxt   = y0 < y1;
      err_nxt  = $signed({3'b000, adx}) - $signed({3'b000, ady});
      cnt_nxt  = 3'd0;
    end else if (busy_r) begin
      if (dot.last) begin
        busy_nxt = 1'b0;
      end else if (line_r) begin
        err_nxt = err_r + (step_x ? -$signed({3'b000, ady_r}) : 13'sd0)
                        + (step_y ? $signed({3'b000, adx_r}) : 13'sd0);
        if (step_x) x_nxt = x_r + xs;
        if (step_y) y_nxt = y_r + ys;
      end else begin
        cnt_nxt = cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      line_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      line_r <= line_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    xe_r  <= xe_nxt;
    ye_r  <= ye_nxt;
    adx_r <= adx_nxt;
    ady_r <= ady_nxt;
    sx_r  <= sx_nxt;
    sy_r  <= sy_nxt;
    err_r <= err_nxt;
  end

endmodule

@@ rtl/bdc_cell_store.sv @@
// cell memory {colour, mask} with a read-modify-write dot pipeline,
// a sweep input for clearing on the same write port and a registered read port; uses bdc_pkg
`timescale 1ns / 1ps

module bdc_cell_store #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 32,
  localparam int DEPTH   = MAX_COLS * MAX_ROWS,
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bdc_pkg::dot_t     dot_i,
  input  logic [7:0]        dot_color,
  input  logic [7:0]        eff_cols,
  input  logic [5:0]        eff_rows,
  input  logic              clr_we,
  input  logic [ADDR_W-1:0] clr_addr,
  input  logic [7:0]        clr_color,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_mask,
  output logic [7:0]        rd_color
);

  logic [15:0] mem [DEPTH];

  logic              p_valid_r, w_valid_r;
  logic [ADDR_W-1:0] p_addr_r, w_addr_r;
  logic [7:0]        p_bit_r, p_col_r;
  logic [15:0]       w_data_r, rd_data_r;

  logic              in_b;
  logic [7:0]        col;
  logic [5:0]        row;
  logic [13:0]       idx;
  logic [ADDR_W-1:0] rd_sel, wr_addr;
  logic [7:0]        base;
  logic              wr_en;
  logic [15:0]       wr_data;

  always_comb begin
    in_b = dot_i.valid && !dot_i.x[10] && !dot_i.y[10]
        && ({1'b0, dot_i.x[9:0]} < {2'b00, eff_cols, 1'b0})
        && ({1'b0, dot_i.y[9:0]} < {3'b000, eff_rows, 2'b00});
    col  = dot_i.x[8:1];
    row  = dot_i.y[7:2];
    idx  = {8'b0, row} * {6'b0, eff_cols} + {6'b0, col};
    rd_sel = dot_i.valid ? ADDR_W'(idx) : rd_addr;

    // forward the write made at the same edge the read data was captured
    base = (w_valid_r && (w_addr_r == p_addr_r)) ? w_data_r[7:0] : rd_data_r[7:0];

    wr_en   = p_valid_r || clr_we;
    wr_addr = p_valid_r ? p_addr_r : clr_addr;
    wr_data = p_valid_r ? {p_col_r, base | p_bit_r} : {clr_color, 8'h00};
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_sel];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      w_valid_r <= 1'b0;
    end else begin
      p_valid_r <= in_b;
      w_valid_r <= wr_en;
    end
    p_addr_r <= ADDR_W'(idx);
    p_bit_r  <= bdc_pkg::dot_bit(dot_i.x[0], dot_i.y[1:0]);
    p_col_r  <= dot_color;
    w_addr_r <= wr_addr;
    w_data_r <= wr_data;
  end

  assign rd_mask  = rd_data_r[7:0];
  assign rd_color = rd_data_r[15:8];

endmodule

@@ rtl/braille_dot_canvas_line_rasterizer.sv @@
// braille dot canvas: one word at a time, ready only while idle
// line: one dot per cycle; clear: the sweep writes one cell per cycle
// the single memory write port (one cell per cycle) carries both the clear sweep and the dots
// after reset a sweep over all MAX_COLS*MAX_ROWS cells zeroes the canvas before the first word
`timescale 1ns / 1ps

module braille_dot_canvas_line_rasterizer #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bdc_in_if.sink                        in_ch,
  bdc_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [bdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

  localparam int DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_CLEAR, ST_DRAW, ST_DRAIN, ST_READ, ST_RDATA, ST_DONE
  } state_t;

  // control and configuration
  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] sweep_r, sweep_nxt;
  logic [7:0]        clear_color_r, clear_color_nxt;
  logic [7:0]        cols_r, cols_nxt;
  logic [5:0]        rows_r, rows_nxt;
  logic              ascii_r, ascii_nxt;
  logic [7:0]        defcol_r, defcol_nxt;
  logic [7:0]        eff_cols_r, eff_cols_nxt;
  logic [5:0]        eff_rows_r, eff_rows_nxt;
  logic [13:0]       total_r, total_nxt;

  // latched command and pending result
  logic [7:0]        color_r, color_nxt;
  logic [11:0]       ci_r, ci_nxt;
  logic [7:0]        res_mask_r, res_mask_nxt;
  logic [7:0]        res_color_r, res_color_nxt;
  logic [13:0]       res_glyph_r, res_glyph_nxt;
  logic              res_read_r, res_read_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_mask_r, out_mask_nxt;
  logic [7:0]        out_color_r, out_color_nxt;
  logic [13:0]       out_glyph_r, out_glyph_nxt;
  logic              out_read_r, out_read_nxt;

  logic              accept, gen_start, clr_we;
  logic              in_range;
  logic [7:0]        rd_mask, rd_color, m_sel, c_sel;
  bdc_pkg::dot_t     dot;

  assign accept    = in_ch.valid && in_ch.ready;
  assign gen_start = accept && ((in_ch.op == bdc_pkg::OP_LINE) || (in_ch.op == bdc_pkg::OP_MARK));
  assign clr_we    = (state_r == ST_INIT) || (state_r == ST_CLEAR);

  // dot source for lines and markers
  bdc_dot_gen u_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (gen_start),
    .mode_line (in_ch.op == bdc_pkg::OP_LINE),
    .x0        (in_ch.x_start),
    .y0        (in_ch.y_start),
    .x1        (in_ch.x_end),
    .y1        (in_ch.y_end),
    .dot       (dot)
  );

  // cell memory with read-modify-write of each dot
  bdc_cell_store #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .dot_i     (dot),
    .dot_color (color_r),
    .eff_cols  (eff_cols_r),
    .eff_rows  (eff_rows_r),
    .clr_we    (clr_we),
    .clr_addr  (sweep_r),
    .clr_color (clear_color_r),
    .rd_addr   (ADDR_W'(ci_r)),
    .rd_mask   (rd_mask),
    .rd_color  (rd_color)
  );

  always_comb begin
    state_nxt       = state_r;
    sweep_nxt       = sweep_r;
    clear_color_nxt = clear_color_r;
    cols_nxt        = cols_r;
    rows_nxt        = rows_r;
    ascii_nxt       = ascii_r;
    defcol_nxt      = defcol_r;
    color_nxt       = color_r;
    ci_nxt          = ci_r;
    res_mask_nxt    = res_mask_r;
    res_color_nxt   = res_color_r;
    res_glyph_nxt   = res_glyph_r;
    res_read_nxt    = res_read_r;
    out_valid_nxt   = out_valid_r;
    out_mask_nxt    = out_mask_r;
    out_color_nxt   = out_color_r;
    out_glyph_nxt   = out_glyph_r;
    out_read_nxt    = out_read_r;

    // configuration writes
    if (cfg_we) begin
      case (cfg_index)
        bdc_pkg::CFG_CANVAS_COLS:   cols_nxt   = cfg_data;
        bdc_pkg::CFG_CANVAS_ROWS:   rows_nxt   = cfg_data[5:0];
        bdc_pkg::CFG_ASCII_GLYPHS:  ascii_nxt  = cfg_data[0];
        bdc_pkg::CFG_DEFAULT_COLOR: defcol_nxt = cfg_data;
        default: ;
      endcase
    end

    // clamp the geometry into 1..MAX, then the cell count for read checks
    if (cols_r == 8'd0) begin
      eff_cols_nxt = 8'd1;
    end else if ({2'b00, cols_r} > 10'(MAX_COLS)) begin
      eff_cols_nxt = 8'(MAX_COLS);
    end else begin
      eff_cols_nxt = cols_r;
    end
    if (rows_r == 6'd0) begin
      eff_rows_nxt = 6'd1;
    end else if ({3'b000, rows_r} > 9'(MAX_ROWS)) begin
      eff_rows_nxt = 6'(MAX_ROWS);
    end else begin
      eff_rows_nxt = rows_r;
    end
    total_nxt = {6'b0, eff_cols_r} * {8'b0, eff_rows_r};

    // read result: cells past the canvas read as empty
    in_range = {2'b00, ci_r} < total_r;
    m_sel    = in_range ? rd_mask : 8'h00;
    c_sel    = in_range ? rd_color : 8'h00;

    // the output register drains independently of the sequencer
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_INIT: begin
        // power-on sweep writes mask zero, colour zero
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == LAST_ADDR) begin
          sweep_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          color_nxt     = in_ch.color;
          ci_nxt        = in_ch.cell_index;
          res_mask_nxt  = 8'h00;
          res_color_nxt = 8'h00;
          res_glyph_nxt = 14'h0000;
          res_read_nxt  = 1'b0;
          case (in_ch.op)
            bdc_pkg::OP_CLEAR: begin
              clear_color_nxt = defcol_r;
              sweep_nxt       = '0;
              state_nxt       = ST_CLEAR;
            end
            bdc_pkg::OP_LINE: state_nxt = ST_DRAW;
            bdc_pkg::OP_MARK: state_nxt = ST_DRAW;
            bdc_pkg::OP_READ: state_nxt = ST_READ;
            default:          state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == LAST_ADDR) begin
          sweep_nxt = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_DRAW: begin
        if (dot.valid && dot.last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        // last dot is written back in this cycle
        state_nxt = ST_DONE;
      end
      ST_READ: begin
        // memory read of ci_r lands at the end of this cycle
        state_nxt = ST_RDATA;
      end
      ST_RDATA: begin
        res_mask_nxt  = m_sel;
        res_color_nxt = c_sel;
        res_glyph_nxt = ascii_r ? bdc_pkg::ascii_glyph(m_sel)
                                : (bdc_pkg::BRAILLE_BASE | {6'b0, m_sel});
        res_read_nxt  = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_mask_nxt  = res_mask_r;
          out_color_nxt = res_color_r;
          out_glyph_nxt = res_glyph_r;
          out_read_nxt  = res_read_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_INIT;
      sweep_r       <= '0;
      clear_color_r <= 8'h00;
      cols_r        <= 8'd128;
      rows_r        <= 6'd32;
      ascii_r       <= 1'b0;
      defcol_r      <= 8'h00;
      eff_cols_r    <= 8'd1;
      eff_rows_r    <= 6'd1;
      total_r       <= 14'd0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      sweep_r       <= sweep_nxt;
      clear_color_r <= clear_color_nxt;
      cols_r        <= cols_nxt;
      rows_r        <= rows_nxt;
      ascii_r       <= ascii_nxt;
      defcol_r      <= defcol_nxt;
      eff_cols_r    <= eff_cols_nxt;
      eff_rows_r    <= eff_rows_nxt;
      total_r       <= total_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    color_r     <= color_nxt;
    ci_r        <= ci_nxt;
    res_mask_r  <= res_mask_nxt;
    res_color_r <= res_color_nxt;
    res_glyph_r <= res_glyph_nxt;
    res_read_r  <= res_read_nxt;
    out_mask_r  <= out_mask_nxt;
    out_color_r <= out_color_nxt;
    out_glyph_r <= out_glyph_nxt;
    out_read_r  <= out_read_nxt;
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_mask  = out_mask_r;
  assign out_ch.cell_color = out_color_r;
  assign out_ch.glyph      = out_glyph_r;
  assign out_ch.read_valid = out_read_r;

  // dots only come out while a draw is in progress
  a_dot_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
    dot.valid |-> (state_r == ST_DRAW))
    else $error("dot issued outside a draw");

  // a word taken closes the input until its result is formed
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("second word accepted while busy");

  // results of non-read commands carry nothing
  a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.read_valid) |->
      (out_ch.cell_mask == 8'h00 && out_ch.cell_color == 8'h00 && out_ch.glyph == 14'h0000))
    else $error("non-read result not zero");

  // a finished result is never overwritten before it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.glyph)))
    else $error("pending result lost");

endmodule
